>>> rtl/core/cpus_pkg.sv
`default_nettype none
package cpus_pkg;

    // register indexes
    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;

    // policy codes
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SRTF = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    // command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] remaining;
        logic [31:0] arrival;
        logic [31:0] halted_at;
        logic        started;
    } entry_t;

    // entry travelling down the cell row looking for its slot
    typedef struct packed {
        logic   valid;
        logic   swap;     // slot already found upstream, push everything down
        logic   by_rem;   // stop at first entry with larger remaining time
        entry_t entry;
    } carry_t;

    typedef struct packed {
        logic        command;
        logic [15:0] process_id;
        logic [15:0] burst_length;
    } in_t;

    typedef struct packed {
        logic [15:0] running_id;
        logic        cpu_idle;
        logic        finished;
        logic [31:0] current_time;
        logic [31:0] idle_ticks;
        logic [47:0] wait_total;
        logic [47:0] response_total;
        logic [47:0] turnaround_total;
        logic        overflow;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_PREEMPT,
        ST_RUN,
        ST_SETTLE
    } st_t;

endpackage
`default_nettype wire

>>> rtl/core/cpus_cell.sv
`default_nettype none
module cpus_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              shift,        // queue head removed: take right neighbor
    input  wire              right_valid,
    input  wire cpus_pkg::entry_t right_entry,
    input  wire cpus_pkg::carry_t carry_in,
    output cpus_pkg::carry_t carry_out,
    output logic             valid,
    output cpus_pkg::entry_t entry
);
    import cpus_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    carry_t carry_reg, carry_next;

    // slot decision for a passing entry, or take the right neighbor on a shift
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        carry_next = carry_in;
        if (shift)
        begin
            valid_next       = right_valid;
            entry_next       = right_entry;
            carry_next.valid = 1'b0;
        end
        else if (carry_in.valid)
        begin
            if (!valid_reg)
            begin
                valid_next       = 1'b1;
                entry_next       = carry_in.entry;
                carry_next.valid = 1'b0;
            end
            else if (carry_in.swap ||
                     (carry_in.by_rem && entry_reg.remaining > carry_in.entry.remaining))
            begin
                entry_next       = carry_in.entry;
                carry_next.swap  = 1'b1;
                carry_next.entry = entry_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign carry_out = carry_reg;
    assign valid     = valid_reg;
    assign entry     = entry_reg;

endmodule
`default_nettype wire

>>> rtl/core/cpu_scheduler_fcfs_srtf_rr_top.sv
`default_nettype none
// Tick-driven CPU scheduler (FCFS, SRTF, round robin) built around a row of
// READY_DEPTH queue cells, head at cell 0. An arrival is injected at cell 0 and
// walks one cell per clock until it finds its slot; an arrival to a full queue
// is dropped and sets the overflow flag. A tick steps through pick, preempt,
// run and back to idle, with a settle state after run while a preempted
// process walks back into the queue. One result is produced per tick, none
// per arrival; no item is taken while a result waits for out_ready.
// Configuration writes take effect at once.
module cpu_scheduler_fcfs_srtf_rr_top #(
    parameter int READY_DEPTH = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire  [1:0]       cfg_index,
    input  wire  [15:0]      cfg_data,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire cpus_pkg::in_t in_data,
    output logic             out_valid,
    input  wire              out_ready,
    output cpus_pkg::out_t   out_data
);
    import cpus_pkg::*;

    localparam int CNT_W = $clog2(READY_DEPTH + 1);

    // configuration
    logic [1:0]  policy_reg;
    logic [15:0] quantum_reg;
    logic [1:0]  pol;
    logic [15:0] quant;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_FCFS;
            quantum_reg <= 16'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY:  policy_reg  <= cfg_data[1:0];
                REG_QUANTUM: quantum_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign pol   = (policy_reg == POL_SRTF || policy_reg == POL_RR) ? policy_reg : POL_FCFS;
    assign quant = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;

    // cell row
    logic                   shift;
    carry_t                 inject;
    carry_t                 carry_out [READY_DEPTH];
    logic   [READY_DEPTH-1:0] cell_valid;
    entry_t                 cell_entry [READY_DEPTH];
    logic   [READY_DEPTH-1:0] carry_busy;
    logic                   busy;

    for (genvar i = 0; i < READY_DEPTH; i++)
    begin : g_cell
        carry_t c_in;
        logic   r_valid;
        entry_t r_entry;
        if (i == 0)
        begin : g_first
            assign c_in = inject;
        end
        else
        begin : g_mid
            assign c_in = carry_out[i-1];
        end
        if (i == READY_DEPTH - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_entry = '0;
        end
        else
        begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_entry = cell_entry[i+1];
        end
        cpus_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift       (shift),
            .right_valid (r_valid),
            .right_entry (r_entry),
            .carry_in    (c_in),
            .carry_out   (carry_out[i]),
            .valid       (cell_valid[i]),
            .entry       (cell_entry[i])
        );
        assign carry_busy[i] = carry_out[i].valid;
    end

    assign busy = |carry_busy;

    // state
    st_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic        run_valid_reg, run_valid_next;
    logic [15:0] run_id_reg, run_id_next;
    logic [15:0] run_rem_reg, run_rem_next;
    logic [31:0] run_arr_reg, run_arr_next;
    logic [15:0] slice_reg, slice_next;
    logic [31:0] time_reg, time_next;
    logic [31:0] idle_reg, idle_next;
    logic [47:0] wait_reg, wait_next;
    logic [47:0] resp_reg, resp_next;
    logic [47:0] turn_reg, turn_next;
    logic        ovf_reg, ovf_next;
    logic        reins_valid_reg, reins_valid_next;
    logic        reins_by_rem_reg, reins_by_rem_next;
    entry_t      reins_entry_reg, reins_entry_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;

    logic        accept;
    logic        full;
    logic        do_pop;
    logic [31:0] since;
    logic [15:0] rem_dec;
    logic [31:0] time_inc;
    logic [31:0] turn_delta;
    entry_t      head;

    assign head   = cell_entry[0];
    assign full   = (count_reg == CNT_W'(READY_DEPTH));
    assign accept = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.command == CMD_TICK)
                        state_next = ST_PICK;
                    else if (!full)
                        state_next = ST_SETTLE;
                end
            end
            ST_PICK:    state_next = ST_PREEMPT;
            ST_PREEMPT: state_next = ST_RUN;
            ST_RUN:     state_next = reins_valid_reg ? ST_SETTLE : ST_IDLE;
            ST_SETTLE:  state_next = busy ? ST_SETTLE : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        in_ready = 1'b0;
        do_pop   = 1'b0;
        case (state_reg)
            ST_IDLE:    in_ready = !out_valid_reg || out_ready;
            ST_PICK:    do_pop = !run_valid_reg && (count_reg != '0);
            ST_PREEMPT: do_pop = run_valid_reg && (count_reg != '0) &&
                                 ((pol == POL_SRTF && head.remaining < run_rem_reg) ||
                                  (pol == POL_RR && slice_reg >= quant));
            default:    ;
        endcase
    end

    assign shift = do_pop;

    // datapath
    always_comb
    begin
        count_next        = count_reg;
        run_valid_next    = run_valid_reg;
        run_id_next       = run_id_reg;
        run_rem_next      = run_rem_reg;
        run_arr_next      = run_arr_reg;
        slice_next        = slice_reg;
        time_next         = time_reg;
        idle_next         = idle_reg;
        wait_next         = wait_reg;
        resp_next         = resp_reg;
        turn_next         = turn_reg;
        ovf_next          = ovf_reg;
        reins_valid_next  = reins_valid_reg;
        reins_by_rem_next = reins_by_rem_reg;
        reins_entry_next  = reins_entry_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        inject            = '0;
        since             = time_reg - (head.started ? head.halted_at : head.arrival);
        rem_dec           = (run_rem_reg != 16'd0) ? run_rem_reg - 16'd1 : 16'd0;
        time_inc          = time_reg + 32'd1;
        turn_delta        = time_inc - run_arr_reg;   // wraps at 32 bits

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // arrival
        if (state_reg == ST_IDLE && accept && in_data.command == CMD_ARRIVE)
        begin
            if (full)
                ovf_next = 1'b1;
            else
            begin
                inject.valid           = 1'b1;
                inject.by_rem          = (pol == POL_SRTF);
                inject.entry.ident     = in_data.process_id;
                inject.entry.remaining = (in_data.burst_length == 16'd0) ?
                                         16'd1 : in_data.burst_length;
                inject.entry.arrival   = time_reg;
                count_next             = count_reg + CNT_W'(1);
            end
        end

        // dispatch of the queue head
        if (do_pop)
        begin
            run_valid_next = 1'b1;
            run_id_next    = head.ident;
            run_rem_next   = head.remaining;
            run_arr_next   = head.arrival;
            slice_next     = 16'd0;
            count_next     = count_reg - CNT_W'(1);
            wait_next      = wait_reg + 48'(since);
            if (!head.started)
                resp_next = resp_reg + 48'(since);
            if (state_reg == ST_PREEMPT)
            begin
                reins_valid_next            = 1'b1;
                reins_by_rem_next           = (pol == POL_SRTF);
                reins_entry_next.ident      = run_id_reg;
                reins_entry_next.remaining  = run_rem_reg;
                reins_entry_next.arrival    = run_arr_reg;
                reins_entry_next.halted_at  = time_reg;
                reins_entry_next.started    = 1'b1;
            end
        end
        else if (state_reg == ST_PREEMPT && run_valid_reg && pol == POL_RR &&
                 slice_reg >= quant)
            slice_next = 16'd0;

        // reinsert a preempted process, run one unit and report
        if (state_reg == ST_RUN)
        begin
            if (reins_valid_reg)
            begin
                inject.valid     = 1'b1;
                inject.by_rem    = reins_by_rem_reg;
                inject.entry     = reins_entry_reg;
                count_next       = count_reg + CNT_W'(1);
                reins_valid_next = 1'b0;
            end
            time_next           = time_inc;
            out_next.running_id = run_valid_reg ? run_id_reg : 16'd0;
            out_next.cpu_idle   = !run_valid_reg;
            out_next.finished   = 1'b0;
            out_next.turnaround_total = turn_reg;
            out_next.idle_ticks = idle_reg;
            if (run_valid_reg)
            begin
                run_rem_next = rem_dec;
                if (slice_reg != 16'hFFFF)
                    slice_next = slice_reg + 16'd1;
                if (rem_dec == 16'd0)
                begin
                    out_next.finished = 1'b1;
                    turn_next         = turn_reg + 48'(turn_delta);
                    out_next.turnaround_total = turn_reg + 48'(turn_delta);
                    run_valid_next    = 1'b0;
                    slice_next        = 16'd0;
                end
            end
            else
            begin
                idle_next           = idle_reg + 32'd1;
                out_next.idle_ticks = idle_reg + 32'd1;
            end
            out_next.current_time   = time_inc;
            out_next.wait_total     = wait_reg;
            out_next.response_total = resp_reg;
            out_next.overflow       = ovf_reg;
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            run_valid_reg   <= 1'b0;
            run_id_reg      <= '0;
            run_rem_reg     <= '0;
            run_arr_reg     <= '0;
            slice_reg       <= '0;
            time_reg        <= '0;
            idle_reg        <= '0;
            wait_reg        <= '0;
            resp_reg        <= '0;
            turn_reg        <= '0;
            ovf_reg         <= 1'b0;
            reins_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            run_valid_reg   <= run_valid_next;
            run_id_reg      <= run_id_next;
            run_rem_reg     <= run_rem_next;
            run_arr_reg     <= run_arr_next;
            slice_reg       <= slice_next;
            time_reg        <= time_next;
            idle_reg        <= idle_next;
            wait_reg        <= wait_next;
            resp_reg        <= resp_next;
            turn_reg        <= turn_next;
            ovf_reg         <= ovf_next;
            reins_valid_reg <= reins_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reins_by_rem_reg <= reins_by_rem_next;
        reins_entry_reg  <= reins_entry_next;
        out_reg          <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(READY_DEPTH))
        else $error("ready count above depth");

    a_no_shift_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> !busy)
        else $error("queue shift while an entry is walking");

    a_inject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        inject.valid |-> !busy)
        else $error("entry injected while another is walking");

    a_settle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && reins_valid_reg) |=> state_reg == ST_SETTLE)
        else $error("reinsert without settle");

endmodule
`default_nettype wire
